[rtl/core/fud_pkg.sv]
// Shared types, character codes and the escape-digit function of the form-urlencoded decoder.
`timescale 1ns / 1ps
`default_nettype none

package fud_pkg;

  // The output offset fields have a fixed width.
  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned FIELD_NUM_W = 8;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  // 'A' - 10, so that 'A' maps to ten.
  localparam logic [7:0] ALPHA_BIAS   = 8'h37;

  typedef enum logic [1:0] {
    ESC_IDLE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } fud_in_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   field_end;
    logic [FIELD_NUM_W-1:0] field_number;
    logic [OFFSET_W-1:0]    next_field_offset;
    logic [OFFSET_W-1:0]    write_offset;
    logic                   message_done;
    logic                   buffer_full;
  } fud_out_t;

  // Value of one escape character: decimal digits map to 0..9, everything
  // else is folded to uppercase and taken relative to 'A' plus ten, mod 256.
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] up;
    begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        nibble_of = c - CHAR_ZERO;
      end else begin
        up = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? (c - CASE_OFFSET) : c;
        nibble_of = up - ALPHA_BIAS;
      end
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/fud_decode.sv]
// Per-byte decode step of the form-urlencoded decoder together with its message state.
`timescale 1ns / 1ps
`default_nettype none

module fud_decode #(
  parameter int unsigned BUFFER_BYTES = 8192,
  parameter int unsigned MAX_FIELDS   = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire fud_pkg::fud_in_t item,
  output logic                  emit,
  output fud_pkg::fud_out_t     result
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned FLD_W = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES);
  localparam logic [FLD_W-1:0] FLD_TOP   = FLD_W'(MAX_FIELDS - 1);

  fud_pkg::esc_phase_t phase, phase_next;
  logic [7:0]          first_nibble;
  logic                first_is_zero;
  logic [CNT_W-1:0]    bytes_written;
  logic [FLD_W-1:0]    fields_closed;

  logic             room;
  logic             wr;
  logic             fend;
  logic             capture;
  logic [7:0]       value;
  logic [7:0]       c;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_after;
  logic [FLD_W-1:0] fld_next;
  logic [FLD_W-1:0] fld_after;
  logic [31:0]      cnt_inc_wide;
  logic [31:0]      cnt_after_wide;
  logic [31:0]      fld_after_wide;

  assign c         = item.in_byte;
  assign room      = bytes_written < CNT_LIMIT;
  assign cnt_inc   = bytes_written + CNT_W'(1);
  assign fld_next  = (fields_closed == FLD_TOP) ? fields_closed : fields_closed + FLD_W'(1);

  // Escape phase sequencing.
  always_comb begin
    phase_next = phase;
    if (room) begin
      unique case (phase)
        fud_pkg::ESC_IDLE: begin
          if (c == fud_pkg::CHAR_PERCENT) begin
            phase_next = fud_pkg::ESC_FIRST;
          end
        end
        fud_pkg::ESC_FIRST:  phase_next = fud_pkg::ESC_SECOND;
        fud_pkg::ESC_SECOND: phase_next = fud_pkg::ESC_IDLE;
        default:             phase_next = fud_pkg::ESC_IDLE;
      endcase
    end
  end

  // Byte decode for the current phase.
  always_comb begin
    wr      = 1'b0;
    fend    = 1'b0;
    capture = 1'b0;
    value   = 8'h00;
    if (room) begin
      unique case (phase)
        fud_pkg::ESC_FIRST: begin
          capture = 1'b1;
        end
        fud_pkg::ESC_SECOND: begin
          wr = 1'b1;
          if (first_is_zero) begin
            value = 8'h00;
          end else if (c == 8'h00) begin
            value = first_nibble;
          end else begin
            value = {first_nibble[3:0], 4'h0} | fud_pkg::nibble_of(c);
          end
        end
        fud_pkg::ESC_IDLE: begin
          priority if (c == fud_pkg::CHAR_PLUS) begin
            wr    = 1'b1;
            value = fud_pkg::CHAR_SPACE;
          end else if (c == fud_pkg::CHAR_AMP || c == fud_pkg::CHAR_NL) begin
            wr   = 1'b1;
            fend = 1'b1;
          end else if (c == fud_pkg::CHAR_PERCENT) begin
            wr = 1'b0;
          end else begin
            wr    = 1'b1;
            value = c;
          end
        end
        default: begin
          wr = 1'b0;
        end
      endcase
    end
  end

  assign cnt_after      = wr ? cnt_inc : bytes_written;
  assign fld_after      = (wr && fend) ? fld_next : fields_closed;
  assign cnt_inc_wide   = 32'(cnt_inc);
  assign cnt_after_wide = 32'(cnt_after);
  assign fld_after_wide = 32'(fld_after);

  assign emit = wr || item.last_byte;

  always_comb begin
    result.out_byte          = value;
    result.byte_valid        = wr;
    result.field_end         = fend;
    result.field_number      = fld_after_wide[fud_pkg::FIELD_NUM_W-1:0];
    result.next_field_offset = fend ? cnt_inc_wide[fud_pkg::OFFSET_W-1:0]
                                    : {fud_pkg::OFFSET_W{1'b0}};
    result.write_offset      = cnt_after_wide[fud_pkg::OFFSET_W-1:0];
    result.message_done      = item.last_byte;
    result.buffer_full       = cnt_after == CNT_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fud_pkg::ESC_IDLE;
      first_nibble  <= 8'h00;
      first_is_zero <= 1'b0;
      bytes_written <= '0;
      fields_closed <= '0;
    end else if (fire) begin
      if (item.last_byte) begin
        phase         <= fud_pkg::ESC_IDLE;
        first_nibble  <= 8'h00;
        first_is_zero <= 1'b0;
        bytes_written <= '0;
        fields_closed <= '0;
      end else begin
        phase <= phase_next;
        if (capture) begin
          first_is_zero <= (c == 8'h00);
          first_nibble  <= (c == 8'h00) ? 8'h00 : fud_pkg::nibble_of(c);
        end
        if (wr) begin
          bytes_written <= cnt_inc;
        end
        if (wr && fend) begin
          fields_closed <= fld_next;
        end
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_written <= CNT_LIMIT)
    else $error("bytes written past the buffer size");

  a_fields_saturate: assert property (@(posedge clk) disable iff (rst)
    fields_closed <= FLD_TOP)
    else $error("field count passed its saturation value");

  a_message_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.last_byte |=> phase == fud_pkg::ESC_IDLE && bytes_written == '0
                               && fields_closed == '0)
    else $error("state not cleared after the final byte of a message");

endmodule

`default_nettype wire

[rtl/core/form_urlencoded_field_decoder_core.sv]
// Top level of the form-urlencoded field decoder: input register, decode step, result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                         | Carries
// --------+---------------------------------+-------------------------------------------
// enc     | enc_valid, enc_ready, enc_data  | one raw byte of the message per transaction
// dec     | dec_valid, dec_ready, dec_data  | one decoded result per transaction
//
// A byte is accepted in every cycle while the pipe flows. Its result, if any, passes from the
// input register through the decode step into the result register. A '%', the first escape
// character and bytes past a full buffer produce no result unless they carry last_byte.
// Reset is synchronous and empties both registers and clears the message state.
// A stalled result holds the result register; one more byte may wait in the input
// register, after which enc_ready drops until dec_ready returns.

module form_urlencoded_field_decoder_core #(
  parameter int unsigned BUFFER_BYTES = 8192,
  parameter int unsigned MAX_FIELDS   = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              enc_valid,
  output logic                   enc_ready,
  input  wire fud_pkg::fud_in_t  enc_data,
  output logic                   dec_valid,
  input  wire logic              dec_ready,
  output fud_pkg::fud_out_t      dec_data
);

  // Input register. It holds a byte until the decode step can run on it,
  // which is whenever the result register is free or being emptied.
  logic              s1_valid;
  fud_pkg::fud_in_t  s1_item;
  logic              s1_move;

  // Decode step outputs for the byte in the input register.
  logic              step_emit;
  fud_pkg::fud_out_t step_result;

  assign s1_move   = s1_valid && (!dec_valid || dec_ready);
  assign enc_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (enc_ready) begin
      s1_valid <= enc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_valid && enc_ready) begin
      s1_item <= enc_data;
    end
  end

  // The decode step commits its state update only when the byte moves on, so a
  // stall never repeats or skips a byte.
  fud_decode #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_FIELDS   (MAX_FIELDS)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_move),
    .item   (s1_item),
    .emit   (step_emit),
    .result (step_result)
  );

  // Result register. Bytes that produce no result pass through without loading it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (s1_move) begin
      dec_valid <= step_emit;
    end else if (dec_ready) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && step_emit) begin
      dec_data <= step_result;
    end
  end

  // A full input register behind a stalled result must block new bytes.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && dec_valid && !dec_ready |-> !enc_ready)
    else $error("input accepted while both registers were held");

  // A result that waits keeps its payload until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_data))
    else $error("waiting result dropped or changed");

  // An empty input register always takes a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> enc_ready)
    else $error("input refused while the input register was empty");

endmodule

`default_nettype wire

[tb/fud_result_checker.sv]
// Scoreboard for the form-urlencoded decoder: predicts every result and compares it on the output channel.
`timescale 1ns / 1ps

module fud_result_checker #(
  parameter int unsigned BUFFER_BYTES = 8192,
  parameter int unsigned MAX_FIELDS   = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              enc_valid,
  input  logic              enc_ready,
  input  fud_pkg::fud_in_t  enc_data,
  input  logic              dec_valid,
  input  logic              dec_ready,
  input  fud_pkg::fud_out_t dec_data,
  output int unsigned       mismatch_count,
  output int unsigned       pending_count
);

  // Shadow copy of the message state.
  fud_pkg::esc_phase_t esc_state   = fud_pkg::ESC_IDLE;
  logic [7:0]          first_value = 8'h00;
  logic                first_nul   = 1'b0;
  int unsigned         written     = 0;
  int unsigned         fields      = 0;

  fud_pkg::fud_out_t   decoded_q[$];
  int unsigned         mismatches  = 0;

  function automatic logic [7:0] escape_value(input logic [7:0] c);
    logic [7:0] folded;
    begin
      if (c >= fud_pkg::CHAR_ZERO && c <= fud_pkg::CHAR_NINE) begin
        return c - fud_pkg::CHAR_ZERO;
      end
      folded = c;
      // Lowercase letters differ from uppercase only in bit 5.
      if (c >= fud_pkg::CHAR_LOW_A && c <= fud_pkg::CHAR_LOW_Z) begin
        folded[5] = 1'b0;
      end
      return folded + 8'd10 - (fud_pkg::CHAR_LOW_A - fud_pkg::CASE_OFFSET);
    end
  endfunction

  function void clear_message();
    esc_state   = fud_pkg::ESC_IDLE;
    first_value = 8'h00;
    first_nul   = 1'b0;
    written     = 0;
    fields      = 0;
  endfunction

  function void decode_raw_byte(input fud_pkg::fud_in_t item);
    logic [7:0]        c;
    logic [7:0]        value;
    logic [7:0]        shifted;
    logic              wrote;
    logic              closed;
    int unsigned       next_off;
    fud_pkg::fud_out_t res;
    begin
      c        = item.in_byte;
      value    = 8'h00;
      wrote    = 1'b0;
      closed   = 1'b0;
      next_off = 0;
      if (written < BUFFER_BYTES) begin
        case (esc_state)
          fud_pkg::ESC_FIRST: begin
            first_nul   = (c == 8'h00);
            first_value = escape_value(c);
            esc_state   = fud_pkg::ESC_SECOND;
          end
          fud_pkg::ESC_SECOND: begin
            shifted = first_value << 4;
            if (first_nul) begin
              value = 8'h00;
            end else if (c == 8'h00) begin
              value = first_value;
            end else begin
              value = shifted | escape_value(c);
            end
            wrote     = 1'b1;
            esc_state = fud_pkg::ESC_IDLE;
          end
          default: begin
            if (c == fud_pkg::CHAR_PLUS) begin
              value = fud_pkg::CHAR_SPACE;
              wrote = 1'b1;
            end else if (c == fud_pkg::CHAR_AMP || c == fud_pkg::CHAR_NL) begin
              wrote  = 1'b1;
              closed = 1'b1;
            end else if (c == fud_pkg::CHAR_PERCENT) begin
              esc_state = fud_pkg::ESC_FIRST;
            end else begin
              value = c;
              wrote = 1'b1;
            end
          end
        endcase
      end

      if (wrote) begin
        written++;
        if (closed) begin
          next_off = written;
          fields++;
          if (fields >= MAX_FIELDS) begin
            fields--;
          end
        end
      end

      if (wrote || item.last_byte) begin
        res.out_byte          = wrote ? value : 8'h00;
        res.byte_valid        = wrote;
        res.field_end         = closed;
        res.field_number      = fud_pkg::FIELD_NUM_W'(fields);
        res.next_field_offset = fud_pkg::OFFSET_W'(next_off);
        res.write_offset      = fud_pkg::OFFSET_W'(written);
        res.message_done      = item.last_byte;
        res.buffer_full       = (written >= BUFFER_BYTES);
        decoded_q.push_back(res);
        if (item.last_byte) begin
          clear_message();
        end
      end
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void compare_result(input fud_pkg::fud_out_t got);
    fud_pkg::fud_out_t want;
    begin
      if (decoded_q.size() == 0) begin
        $error("result: expected none, actual 0x%0h", got);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
      check_field("field_end", 32'(want.field_end), 32'(got.field_end));
      check_field("field_number", 32'(want.field_number), 32'(got.field_number));
      check_field("next_field_offset", 32'(want.next_field_offset),
                  32'(got.next_field_offset));
      check_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
      check_field("message_done", 32'(want.message_done), 32'(got.message_done));
      check_field("buffer_full", 32'(want.buffer_full), 32'(got.buffer_full));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      decoded_q.delete();
    end else begin
      if (enc_valid && enc_ready) begin
        decode_raw_byte(enc_data);
      end
      if (dec_valid && dec_ready) begin
        compare_result(dec_data);
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= 32'(decoded_q.size());
  end

endmodule

[tb/tb_form_urlencoded_field_decoder_core.sv]
// Top of the decoder testbench: clock, reset, byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_form_urlencoded_field_decoder_core;

  // The block runs with its default sizes; the checker is given the same ones.
  localparam int unsigned BUFFER_BYTES = 8192;
  localparam int unsigned MAX_FIELDS   = 256;

  // Roughly this many bytes are sent over the whole run.
  localparam int unsigned ITEM_TARGET = 1950;

  // The result of a byte passes through the input and result registers; the drain
  // waits on past the expected results so that a stray extra result would still be seen.
  localparam int unsigned DRAIN_CYCLES = 8;

  // Gaps on either side are drawn from pick_gap and are far shorter, so a silence this
  // long means the block has hung.
  localparam int unsigned IDLE_LIMIT = 2000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              enc_valid = 1'b0;
  logic              enc_ready;
  fud_pkg::fud_in_t  enc_data  = '0;
  logic              dec_valid;
  logic              dec_ready = 1'b0;
  fud_pkg::fud_out_t dec_data;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // When calm is set, neither side idles, which gives back-to-back stretches.
  logic        calm        = 1'b0;
  int unsigned ready_hold  = 0;
  int unsigned sent_items  = 0;
  int unsigned idle_cycles = 0;

  // Bytes of the message being built, sent in order with last_byte on the final one.
  logic [7:0]  msg_q[$];

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  form_urlencoded_field_decoder_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_FIELDS   (MAX_FIELDS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc_data  (enc_data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

  fud_result_checker #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_FIELDS   (MAX_FIELDS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .enc_valid      (enc_valid),
    .enc_ready      (enc_ready),
    .enc_data       (enc_data),
    .dec_valid      (dec_valid),
    .dec_ready      (dec_ready),
    .dec_data       (dec_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Gap lengths are mostly zero or short, with an occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    begin
      if (calm) begin
        return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        return 0;
      end else if (r < 88) begin
        return $urandom_range(1, 3);
      end else if (r < 97) begin
        return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
    end
  endfunction

  // A hex digit in either case, the normal content of an escape.
  function automatic logic [7:0] hex_char();
    int unsigned r;
    begin
      r = $urandom_range(0, 21);
      if (r < 10) begin
        return fud_pkg::CHAR_ZERO + 8'(r);
      end else if (r < 16) begin
        return fud_pkg::CHAR_LOW_A + 8'(r - 10);
      end
      return (fud_pkg::CHAR_LOW_A - fud_pkg::CASE_OFFSET) + 8'(r - 16);
    end
  endfunction

  // Any byte that does not open an escape, so that it writes exactly one byte.
  function automatic logic [7:0] any_but_percent();
    logic [7:0] b;
    begin
      b = 8'($urandom_range(0, 255));
      if (b == fud_pkg::CHAR_PERCENT) begin
        b = fud_pkg::CHAR_PLUS;
      end
      return b;
    end
  endfunction

  // The result side holds ready high or low for random stretches. A stalled
  // result makes the block drop enc_ready once its input register fills, so
  // these stretches also push back on the byte stream.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      dec_ready <= 1'b1;
    end else if ($urandom_range(0, 2) != 0) begin
      dec_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 10);
    end else begin
      dec_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // One transaction on the byte channel. Valid only drops when a gap is
  // taken; otherwise the next byte follows directly, so valid is never
  // lowered and raised in the same time step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    begin
      gap = pick_gap();
      if (gap != 0) begin
        enc_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      enc_valid <= 1'b1;
      enc_data  <= '{in_byte: b, last_byte: fin};
      @(posedge clk);
      while (!enc_ready) @(posedge clk);
    end
  endtask

  task automatic send_message();
    begin
      foreach (msg_q[i]) begin
        send_byte(msg_q[i], i == msg_q.size() - 1);
      end
      sent_items += msg_q.size();
      msg_q.delete();
    end
  endtask

  // A percent sign and two characters; a wild escape may carry any byte,
  // zero among them.
  task automatic add_escape(input logic wild);
    begin
      msg_q.push_back(fud_pkg::CHAR_PERCENT);
      msg_q.push_back(wild ? 8'($urandom_range(0, 255)) : hex_char());
      msg_q.push_back(wild ? 8'($urandom_range(0, 255)) : hex_char());
    end
  endtask

  // One piece of a well-formed message, with a little raw noise mixed in.
  task automatic add_random_token();
    int unsigned r;
    begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        msg_q.push_back(any_but_percent());
      end else if (r < 52) begin
        msg_q.push_back(fud_pkg::CHAR_PLUS);
      end else if (r < 68) begin
        msg_q.push_back(($urandom_range(0, 1) != 0) ? fud_pkg::CHAR_AMP : fud_pkg::CHAR_NL);
      end else if (r < 94) begin
        add_escape($urandom_range(0, 4) == 0);
      end else begin
        // A raw byte, possibly a stray percent that swallows what follows.
        msg_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // A message with more field ends than the field count can hold, so the
  // count reaches its saturation value and stays there. A few data bytes
  // sit between the separators.
  task automatic add_field_saturating_message();
    int unsigned ends;
    begin
      ends = 0;
      while (ends < MAX_FIELDS + 24) begin
        if ($urandom_range(0, 9) == 0) begin
          msg_q.push_back(any_but_percent());
        end else begin
          msg_q.push_back(($urandom_range(0, 1) != 0) ? fud_pkg::CHAR_AMP : fud_pkg::CHAR_NL);
          ends++;
        end
      end
      msg_q.push_back("x");
    end
  endtask

  // Watchdog: a long run of cycles with no transaction on either channel
  // ends the run as a failure.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((enc_valid && enc_ready) || (dec_valid && dec_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("form_urlencoded_field_decoder_core: mismatch");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first message mixes every plain kind of byte: an
    // ordinary letter, a plus, a zero byte copied as data, both field
    // separators, the top byte value, and ends on a complete escape.
    msg_q = '{"a", fud_pkg::CHAR_PLUS, 8'h00, fud_pkg::CHAR_AMP, "Z", fud_pkg::CHAR_NL,
              8'hFF, fud_pkg::CHAR_PERCENT, "4", "1"};
    send_message();

    // Escapes: lowercase letters, a zero byte as the first character, a zero
    // byte as the second, characters outside the hex range, and finally a
    // message that ends on the percent sign itself.
    msg_q = '{fud_pkg::CHAR_PERCENT, "z", "f", fud_pkg::CHAR_PERCENT, 8'h00, "7",
              fud_pkg::CHAR_PERCENT, "3", 8'h00, fud_pkg::CHAR_PERCENT, "G", 8'hFF,
              fud_pkg::CHAR_PERCENT};
    send_message();

    // A message that ends on the first escape character, then one that is a
    // lone field separator.
    msg_q = '{fud_pkg::CHAR_PERCENT, "A"};
    send_message();
    msg_q = '{fud_pkg::CHAR_AMP};
    send_message();

    // Field count saturation, then the state must be clean for the random
    // messages that follow.
    add_field_saturating_message();
    send_message();

    // Random part: mostly well-formed messages with random content, some of
    // them cut short inside an escape, and now and then pure noise.
    while (sent_items < ITEM_TARGET) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) add_random_token();
        r = $urandom_range(0, 7);
        if (r == 0) begin
          msg_q.push_back(fud_pkg::CHAR_PERCENT);
        end else if (r == 1) begin
          msg_q.push_back(fud_pkg::CHAR_PERCENT);
          msg_q.push_back(hex_char());
        end
      end
      send_message();
    end
    calm = 1'b0;

    // Stop sending, let the last byte's result through, and wait out the
    // expected results. The extra edge lets the pending count catch up with
    // the final transaction.
    enc_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("form_urlencoded_field_decoder_core: match");
    end else begin
      $display("form_urlencoded_field_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
